FILE: design/fvcw_pkg.sv
// ----------------------------------------------------------------------------
// fvcw_pkg: shared constants and tables for the flow vector colour wheel
// Holds the fixed widths, the arctangent steps and the 55-entry colour wheel.
// ----------------------------------------------------------------------------
`default_nettype none

package fvcw_pkg;

	localparam int unsigned WHEEL_ENTRIES = 55;
	localparam int unsigned ANGLE_PI      = 4096;
	localparam int unsigned INV_GAIN      = 39797;
	localparam int unsigned XW            = 28;   // CORDIC x/y datapath
	localparam int unsigned ZW            = 14;   // angle, units of pi, Q12
	localparam int unsigned NUMW          = 43;   // magnitude times gain correction
	localparam int unsigned DW            = 20;   // divisor: max_motion * 16
	localparam int unsigned QW            = 13;   // radius quotient, Q12
	localparam int unsigned CW            = 20;   // blended colour, 255*col in Q12
	localparam int unsigned KW            = 6;    // wheel index

	typedef logic [2:0][CW-1:0] rgb_c_t;
	typedef logic [2:0][7:0]    rgb8_t;

	// round(atan(2^-i)/pi * 4096)
	function automatic logic [10:0] atan_q12(input int unsigned i);
		logic [10:0] r;
		case (i)
			0:  r = 11'd1024;
			1:  r = 11'd605;
			2:  r = 11'd319;
			3:  r = 11'd162;
			4:  r = 11'd81;
			5:  r = 11'd41;
			6:  r = 11'd20;
			7:  r = 11'd10;
			8:  r = 11'd5;
			9:  r = 11'd3;
			10: r = 11'd1;
			11: r = 11'd1;
			default: r = 11'd0;
		endcase
		return r;
	endfunction

	// Wheel entry k, channels packed red (2), green (1), blue (0).
	// Segments: red-yellow 15, yellow-green 6, green-cyan 4, cyan-blue 11,
	// blue-magenta 13, magenta-red 6; each step is the truncated fraction of 255.
	function automatic rgb8_t wheel(input logic [KW-1:0] k);
		rgb8_t r;
		case (k)
			6'd0:  r = 24'hFF0000;
			6'd1:  r = 24'hFF1100;
			6'd2:  r = 24'hFF2200;
			6'd3:  r = 24'hFF3300;
			6'd4:  r = 24'hFF4400;
			6'd5:  r = 24'hFF5500;
			6'd6:  r = 24'hFF6600;
			6'd7:  r = 24'hFF7700;
			6'd8:  r = 24'hFF8800;
			6'd9:  r = 24'hFF9900;
			6'd10: r = 24'hFFAA00;
			6'd11: r = 24'hFFBB00;
			6'd12: r = 24'hFFCC00;
			6'd13: r = 24'hFFDD00;
			6'd14: r = 24'hFFEE00;
			6'd15: r = 24'hFFFF00;
			6'd16: r = 24'hD5FF00;
			6'd17: r = 24'hAAFF00;
			6'd18: r = 24'h80FF00;
			6'd19: r = 24'h55FF00;
			6'd20: r = 24'h2BFF00;
			6'd21: r = 24'h00FF00;
			6'd22: r = 24'h00FF3F;
			6'd23: r = 24'h00FF7F;
			6'd24: r = 24'h00FFBF;
			6'd25: r = 24'h00FFFF;
			6'd26: r = 24'h00E8FF;
			6'd27: r = 24'h00D1FF;
			6'd28: r = 24'h00BAFF;
			6'd29: r = 24'h00A3FF;
			6'd30: r = 24'h008CFF;
			6'd31: r = 24'h0074FF;
			6'd32: r = 24'h005DFF;
			6'd33: r = 24'h0046FF;
			6'd34: r = 24'h002FFF;
			6'd35: r = 24'h0018FF;
			6'd36: r = 24'h0000FF;
			6'd37: r = 24'h1300FF;
			6'd38: r = 24'h2700FF;
			6'd39: r = 24'h3A00FF;
			6'd40: r = 24'h4E00FF;
			6'd41: r = 24'h6200FF;
			6'd42: r = 24'h7500FF;
			6'd43: r = 24'h8900FF;
			6'd44: r = 24'h9C00FF;
			6'd45: r = 24'hB000FF;
			6'd46: r = 24'hC400FF;
			6'd47: r = 24'hD700FF;
			6'd48: r = 24'hEB00FF;
			6'd49: r = 24'hFF00FF;
			6'd50: r = 24'hFF00D5;
			6'd51: r = 24'hFF00AA;
			6'd52: r = 24'hFF0080;
			6'd53: r = 24'hFF0055;
			// past the end reads as the last entry
			default: r = 24'hFF002B;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/flow_vector_color_wheel.sv
// ----------------------------------------------------------------------------
// flow_vector_color_wheel: optical flow vector to RGB colour wheel
// Pipeline: stage 0, the CORDIC stages, stages M, P, W and B, the division steps, stage F, output.
// Throughput: one pixel per cycle; the whole pipe holds while a valid output is stalled.
// The CORDIC stages and the 13 restoring-division steps for the radius set depth.
// Reset: asynchronous, active low; clears valid bits and loads max_motion = 2560.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_vector_color_wheel #(
	parameter int unsigned CORDIC_STAGES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [23:0] flow_x,
	input  wire logic signed [23:0] flow_y,
	input  wire logic               flow_valid,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              red,
	output logic [7:0]              green,
	output logic [7:0]              blue
);

	localparam int unsigned XW   = fvcw_pkg::XW;
	localparam int unsigned ZW   = fvcw_pkg::ZW;
	localparam int unsigned NUMW = fvcw_pkg::NUMW;
	localparam int unsigned DW   = fvcw_pkg::DW;
	localparam int unsigned QW   = fvcw_pkg::QW;
	localparam int unsigned CW   = fvcw_pkg::CW;
	localparam int unsigned KW   = fvcw_pkg::KW;

	// Configuration register
	logic [15:0] max_motion_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_motion_q <= 16'd2560;
		end else if (cfg_we) begin
			max_motion_q <= cfg_wdata;
		end
	end

	// Divisor: zero is treated as one, then scaled by 16
	logic [DW-1:0] divisor;
	assign divisor = {((max_motion_q == 16'd0) ? 16'd1 : max_motion_q), 4'd0};

	// Global advance: the pipe moves unless a finished result is held back
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// ------------------------------------------------------------------
	// Stage 0: negate the vector and pre-rotate into the right half plane
	// ------------------------------------------------------------------
	logic signed [XW-1:0] cx_s [0:CORDIC_STAGES];
	logic signed [XW-1:0] cy_s [0:CORDIC_STAGES];
	logic signed [ZW-1:0] cz_s [0:CORDIC_STAGES];
	logic                 cok_s [0:CORDIC_STAGES];
	logic                 cv_s [0:CORDIC_STAGES];

	logic signed [XW-1:0] nx;
	logic signed [XW-1:0] ny;
	logic signed [XW-1:0] px;
	logic signed [XW-1:0] py;
	logic signed [ZW-1:0] pz;

	always_comb begin
		nx = -XW'(flow_x);
		ny = -XW'(flow_y);
		px = nx;
		py = ny;
		pz = '0;
		if (nx < 0) begin
			if (ny >= 0) begin
				px = ny;
				py = -nx;
				pz = ZW'(fvcw_pkg::ANGLE_PI / 2);
			end else begin
				px = -ny;
				py = nx;
				pz = -ZW'(fvcw_pkg::ANGLE_PI / 2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else if (en) begin
			cv_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0]  <= px;
			cy_s[0]  <= py;
			cz_s[0]  <= pz;
			cok_s[0] <= flow_valid;
		end
	end

	// ------------------------------------------------------------------
	// CORDIC vectoring: one micro-rotation per stage, drive y toward zero
	// ------------------------------------------------------------------
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;
		logic signed [ZW-1:0] at;

		assign dx = cy_s[g] >>> g;
		assign dy = cx_s[g] >>> g;
		assign at = ZW'($signed({1'b0, fvcw_pkg::atan_q12(g)}));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[g+1] <= 1'b0;
			end else if (en) begin
				cv_s[g+1] <= cv_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_s[g] >= 0) begin
					cx_s[g+1] <= cx_s[g] + dx;
					cy_s[g+1] <= cy_s[g] - dy;
					cz_s[g+1] <= cz_s[g] + at;
				end else begin
					cx_s[g+1] <= cx_s[g] - dx;
					cy_s[g+1] <= cy_s[g] + dy;
					cz_s[g+1] <= cz_s[g] - at;
				end
				cok_s[g+1] <= cok_s[g];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage M: clamp the angle, apply the gain correction to the magnitude
	// ------------------------------------------------------------------
	logic signed [XW-1:0] fx;
	logic signed [ZW-1:0] fz;
	logic signed [ZW-1:0] zc;
	logic [XW-2:0]        mag;

	assign fx  = cx_s[CORDIC_STAGES];
	assign fz  = cz_s[CORDIC_STAGES];
	assign mag = (fx > 0) ? fx[XW-2:0] : '0;

	always_comb begin
		zc = fz;
		if (fz > $signed(ZW'(fvcw_pkg::ANGLE_PI))) zc = ZW'(fvcw_pkg::ANGLE_PI);
		if (fz < -$signed(ZW'(fvcw_pkg::ANGLE_PI))) zc = -ZW'(fvcw_pkg::ANGLE_PI);
	end

	logic [NUMW-1:0] num_sm;
	logic [ZW-1:0]   u_sm;
	logic            ok_sm;
	logic            v_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sm <= 1'b0;
		end else if (en) begin
			v_sm <= cv_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_sm <= NUMW'(mag) * NUMW'(fvcw_pkg::INV_GAIN);
			u_sm   <= ZW'(zc + $signed(ZW'(fvcw_pkg::ANGLE_PI)));
			ok_sm  <= cok_s[CORDIC_STAGES];
		end
	end

	// ------------------------------------------------------------------
	// Stage P: wheel position, and the head of the radius division
	// ------------------------------------------------------------------
	logic [18:0]   pos;
	logic [KW-1:0] k0;
	logic          big;

	assign pos = 19'(u_sm) * 19'(fvcw_pkg::WHEEL_ENTRIES - 1);
	assign k0  = (pos[18:13] > KW'(fvcw_pkg::WHEEL_ENTRIES - 1)) ?
		KW'(fvcw_pkg::WHEEL_ENTRIES - 1) : pos[18:13];
	// Quotient does not fit in QW bits: certainly beyond unit radius
	assign big = num_sm[NUMW-1:QW] >= (NUMW - QW)'(divisor);

	logic [KW-1:0] k0_sp;
	logic [KW-1:0] k1_sp;
	logic [11:0]   f_sp;
	logic [DW-1:0] rem_sp;
	logic [QW-1:0] lo_sp;
	logic          big_sp;
	logic          ok_sp;
	logic          v_sp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sp <= 1'b0;
		end else if (en) begin
			v_sp <= v_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k0_sp  <= k0;
			k1_sp  <= (k0 == KW'(fvcw_pkg::WHEEL_ENTRIES - 1)) ? '0 : k0 + KW'(1);
			f_sp   <= pos[12:1];
			rem_sp <= num_sm[QW+DW-1:QW];
			lo_sp  <= num_sm[QW-1:0];
			big_sp <= big;
			ok_sp  <= ok_sm;
		end
	end

	// ------------------------------------------------------------------
	// Stage W: look up the two neighbouring wheel entries
	// ------------------------------------------------------------------
	fvcw_pkg::rgb8_t w0_sw;
	fvcw_pkg::rgb8_t w1_sw;
	logic [11:0]     f_sw;
	logic [DW-1:0]   rem_sw;
	logic [QW-1:0]   lo_sw;
	logic            big_sw;
	logic            ok_sw;
	logic            v_sw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sw <= 1'b0;
		end else if (en) begin
			v_sw <= v_sp;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w0_sw  <= fvcw_pkg::wheel(k0_sp);
			w1_sw  <= fvcw_pkg::wheel(k1_sp);
			f_sw   <= f_sp;
			rem_sw <= rem_sp;
			lo_sw  <= lo_sp;
			big_sw <= big_sp;
			ok_sw  <= ok_sp;
		end
	end

	// ------------------------------------------------------------------
	// Stage B: blend the two entries per channel
	// ------------------------------------------------------------------
	fvcw_pkg::rgb_c_t blend;
	logic [12:0]      fw0;

	assign fw0 = 13'd4096 - 13'(f_sw);

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			blend[ch] = CW'(21'(fw0) * 21'(w0_sw[ch]) + 21'(f_sw) * 21'(w1_sw[ch]));
		end
	end

	// Division pipe, entry 0 is the blend stage
	logic [DW-1:0]    rem_s [0:QW];
	logic [QW-1:0]    lo_s  [0:QW];
	logic [QW-1:0]    q_s   [0:QW];
	logic             big_s [0:QW];
	logic             ok_s  [0:QW];
	fvcw_pkg::rgb_c_t c_s   [0:QW];
	logic             v_s   [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_sw;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rem_sw;
			lo_s[0]  <= lo_sw;
			q_s[0]   <= '0;
			big_s[0] <= big_sw;
			ok_s[0]  <= ok_sw;
			c_s[0]   <= blend;
		end
	end

	// ------------------------------------------------------------------
	// Restoring division: one quotient bit per stage
	// ------------------------------------------------------------------
	for (genvar t = 0; t < QW; t++) begin : g_div
		logic [DW:0] trial;

		assign trial = {rem_s[t], lo_s[t][QW-1]} - {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[t+1] <= 1'b0;
			end else if (en) begin
				v_s[t+1] <= v_s[t];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[DW]) begin
					rem_s[t+1] <= trial[DW-1:0];
					q_s[t+1]   <= {q_s[t][QW-2:0], 1'b1};
				end else begin
					rem_s[t+1] <= {rem_s[t][DW-2:0], lo_s[t][QW-1]};
					q_s[t+1]   <= {q_s[t][QW-2:0], 1'b0};
				end
				lo_s[t+1]  <= {lo_s[t][QW-2:0], 1'b0};
				big_s[t+1] <= big_s[t];
				ok_s[t+1]  <= ok_s[t];
				c_s[t+1]   <= c_s[t];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage F: desaturate toward white, or dim beyond unit radius
	// ------------------------------------------------------------------
	logic [QW-1:0]    rad;
	fvcw_pkg::rgb_c_t cf;

	assign rad = q_s[QW];
	assign cf  = c_s[QW];

	logic [2:0][32:0] prod_sf;
	fvcw_pkg::rgb8_t  dim_sf;
	logic             within_sf;
	logic             ok_sf;
	logic             v_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (en) begin
			v_sf <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				prod_sf[ch] <= 33'(rad) * 33'(CW'(255 * 4096) - cf[ch]);
				dim_sf[ch]  <= 8'((22'(cf[ch]) * 22'd3) >> 14);
			end
			within_sf <= !big_s[QW] && (rad <= QW'(4096));
			ok_sf     <= ok_s[QW];
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	fvcw_pkg::rgb8_t  col;
	logic [2:0][33:0] full;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			full[ch] = (34'd255 << 24) - 34'(prod_sf[ch]);
			if (!ok_sf) begin
				col[ch] = '0;
			end else if (within_sf) begin
				col[ch] = full[ch][31:24];
			end else begin
				col[ch] = dim_sf[ch];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_sf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red   <= col[2];
			green <= col[1];
			blue  <= col[0];
		end
	end

endmodule

`default_nettype wire
